FILE: src/pd_pkg.sv
`default_nettype none
package pd_pkg;

   // Sizes of the stores and fields
   localparam int MAX_WIDTH   = 1024;
   localparam int ADDR_W      = 10;
   localparam int CNT_W       = 11;
   localparam int PAL_DEPTH   = 16;
   localparam int PAL_IDX_W   = 4;
   localparam int PAL_CNT_W   = 5;
   localparam int ERR_W       = 13;
   localparam int ERR_WORD_W  = 3 * ERR_W;
   localparam int DIST_W      = 18;

   // Dither modes
   localparam logic [1:0] MODE_DIFFUSE = 2'd0;
   localparam logic [1:0] MODE_BAYER4  = 2'd1;
   localparam logic [1:0] MODE_ORDER8  = 2'd2;
   localparam logic [1:0] MODE_PASS    = 2'd3;

   // Register indexes
   localparam logic [1:0] CSR_MODE   = 2'd0;
   localparam logic [1:0] CSR_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_PALCNT = 2'd2;

   // Request kinds
   localparam logic KIND_PALETTE = 1'b0;
   localparam logic KIND_PIXEL   = 1'b1;

   // Threshold maps, indexed by {row, column}
   localparam logic [3:0] BAYER4 [16] = '{
      4'd0, 4'd8, 4'd2, 4'd10, 4'd12, 4'd4, 4'd14, 4'd6,
      4'd3, 4'd11, 4'd1, 4'd9, 4'd15, 4'd7, 4'd13, 4'd5};

   localparam logic [5:0] ORDER8 [64] = '{
      6'd0, 6'd48, 6'd12, 6'd60, 6'd3, 6'd51, 6'd15, 6'd63,
      6'd32, 6'd16, 6'd44, 6'd28, 6'd35, 6'd19, 6'd47, 6'd31,
      6'd8, 6'd56, 6'd4, 6'd52, 6'd11, 6'd59, 6'd7, 6'd55,
      6'd40, 6'd24, 6'd36, 6'd20, 6'd43, 6'd27, 6'd39, 6'd23,
      6'd2, 6'd50, 6'd14, 6'd62, 6'd1, 6'd49, 6'd13, 6'd61,
      6'd34, 6'd18, 6'd46, 6'd30, 6'd33, 6'd17, 6'd45, 6'd29,
      6'd10, 6'd58, 6'd6, 6'd54, 6'd9, 6'd57, 6'd5, 6'd53,
      6'd42, 6'd26, 6'd38, 6'd22, 6'd41, 6'd25, 6'd37, 6'd21};

   // Status of the nearest-colour search
   typedef struct packed {
      logic                 done;
      logic [PAL_IDX_W-1:0] index;
      logic [23:0]          rgb;
   } srch_stat_type;

endpackage
`default_nettype wire

FILE: src/pd_ram.sv
`default_nettype none
module pd_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 39
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port (read returns old data)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

FILE: src/pd_search.sv
`default_nettype none
module pd_search (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          pal_we,
   input  wire logic [pd_pkg::PAL_IDX_W-1:0]  pal_idx,
   input  wire logic [23:0]                   pal_rgb,
   input  wire logic                          start,
   input  wire logic [23:0]                   target,
   input  wire logic [pd_pkg::PAL_CNT_W-1:0]  count,
   output pd_pkg::srch_stat_type              stat
);
   import pd_pkg::*;

   logic [23:0]          pal_ff [PAL_DEPTH];
   logic [PAL_IDX_W-1:0] idx_ff, idx_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIST_W-1:0]    best_d_ff, best_d_in;
   logic [PAL_IDX_W-1:0] best_i_ff, best_i_in;
   logic [23:0]          best_rgb_ff, best_rgb_in;

   logic [23:0]          entry;
   logic signed [17:0]   sq [3];
   logic [DIST_W-1:0]    cand_d;
   logic                 last;

   // Palette store, written from palette requests
   always_ff @(posedge clock) begin
      if (pal_we) begin
         pal_ff[pal_idx] <= pal_rgb;
      end
   end

   // Distance of one palette entry per cycle
   always_comb begin
      entry = pal_ff[idx_ff];
      for (int k = 0; k < 3; k++) begin
         sq[k] = signed'({10'd0, target[23-8*k -: 8]} - {10'd0, entry[23-8*k -: 8]})
               * signed'({10'd0, target[23-8*k -: 8]} - {10'd0, entry[23-8*k -: 8]});
      end
      cand_d = DIST_W'(sq[0]) + DIST_W'(sq[1]) + DIST_W'(sq[2]);
      last   = ({1'b0, idx_ff} + PAL_CNT_W'(1)) >= count;
   end

   // Step through the entries, keep the first minimum
   always_comb begin
      idx_in      = idx_ff;
      busy_in     = busy_ff;
      done_in     = 1'b0;
      best_d_in   = best_d_ff;
      best_i_in   = best_i_ff;
      best_rgb_in = best_rgb_ff;
      if (start) begin
         idx_in    = '0;
         busy_in   = 1'b1;
         best_d_in = '1;
      end else if (busy_ff) begin
         if (cand_d < best_d_ff) begin
            best_d_in   = cand_d;
            best_i_in   = idx_ff;
            best_rgb_in = entry;
         end
         idx_in = idx_ff + PAL_IDX_W'(1);
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         idx_ff  <= idx_in;
      end
      best_d_ff   <= best_d_in;
      best_i_ff   <= best_i_in;
      best_rgb_ff <= best_rgb_in;
   end

   assign stat.done  = done_ff;
   assign stat.index = best_i_ff;
   assign stat.rgb   = best_rgb_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("search done without a running search");

endmodule
`default_nettype wire

FILE: src/palette_dither_core.sv
//  channel | direction | signals
//  req     | in        | req_tvalid, req_tready, req_tdata[55:0], req_tuser[1:0]
//  rsp     | out       | rsp_tvalid, rsp_tready, rsp_tdata[31:0], rsp_tlast
//  csr     | in        | csr_wr_en, csr_index[1:0], csr_wr_data[10:0]
//
//  A palette request leaves the core idle and ready. A pixel is searched over N palette
//  entries in the ordered, Bayer and error diffusion modes, the last adding error sharing
//  steps: the search unit compares one palette entry per cycle; passthrough skips it.
//  After reset a clearing pass zeroes all 1024 entries of both error line stores;
//  a frame start sweeps the entries used so far (up to 1024 entries) first.
//  A row end sweeps stale entries left beyond a shortened row.
//  A pixel waits in the output step while the previous result is not taken.
`default_nettype none
module palette_dither_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [55:0] req_tdata,   // entry_index, entry_rgb, pixel_rgb, zero pad
   input  wire logic [1:0]  req_tuser,   // kind, frame_start
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // out_rgb, out_index, zero pad
   output logic             rsp_tlast,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [10:0] csr_wr_data
);
   import pd_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b00000001,
      ST_SWEEP  = 8'b00000010,
      ST_READ   = 8'b00000100,
      ST_ADJ    = 8'b00001000,
      ST_SEARCH = 8'b00010000,
      ST_DIFF   = 8'b00100000,
      ST_END    = 8'b01000000,
      ST_OUT    = 8'b10000000
   } state_type;

   state_type state_ff, state_in, ret_ff, ret_in;

   logic [1:0]            mode_ff;
   logic [CNT_W-1:0]      width_ff;
   logic [PAL_CNT_W-1:0]  palcnt_ff;

   logic [23:0]           pix_ff, pix_in;
   logic [23:0]           chan_ff, chan_in;
   logic [ADDR_W-1:0]     col_ff, col_in;
   logic [2:0]            row_ff, row_in;
   logic                  sel_ff, sel_in;
   logic [CNT_W-1:0]      cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic [ERR_WORD_W-1:0] carry_ff, carry_in;
   logic [CNT_W-1:0]      clr_addr_ff, clr_addr_in, clr_end_ff, clr_end_in;
   logic                  clr_a_ff, clr_a_in, clr_b_ff, clr_b_in;
   logic [1:0]            step_ff, step_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [31:0]           rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  req_take;
   logic [CNT_W-1:0]      w_eff;
   logic [PAL_CNT_W-1:0]  n_eff;
   logic                  last;
   logic [CNT_W-1:0]      col_next;
   logic [CNT_W-1:0]      cnt_this, cnt_next;

   logic                  a_we, b_we;
   logic [ADDR_W-1:0]     a_waddr, b_waddr, a_raddr, b_raddr;
   logic [ERR_WORD_W-1:0] a_wdata, b_wdata, a_rdata, b_rdata;
   logic [ERR_WORD_W-1:0] this_rd, next_rd;

   logic                  this_we, next_we;
   logic [ADDR_W-1:0]     this_addr, next_raddr, next_waddr;
   logic [ERR_WORD_W-1:0] next_wdata;
   logic [CNT_W-1:0]      diff_rsum, diff_wsum;
   logic                  diff_ok;

   logic signed [ERR_W-1:0] err_sum [3];
   logic signed [ERR_W-1:0] err_rnd [3];
   logic signed [9:0]       adj [3];
   logic signed [10:0]      adj_sum [3];
   logic signed [ERR_W-1:0] e13 [3];
   logic signed [ERR_W-1:0] wgt [3];
   logic [ERR_WORD_W-1:0]   seven_e;

   logic                  srch_start;
   srch_stat_type         srch_stat;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_DIFFUSE;
         width_ff  <= CNT_W'(MAX_WIDTH);
         palcnt_ff <= PAL_CNT_W'(1);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MODE:   mode_ff   <= csr_wr_data[1:0];
            CSR_WIDTH:  width_ff  <= csr_wr_data;
            CSR_PALCNT: palcnt_ff <= csr_wr_data[PAL_CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Clip width and palette count, flag the row's last pixel
   always_comb begin
      if (width_ff == '0)                     w_eff = CNT_W'(1);
      else if (width_ff > CNT_W'(MAX_WIDTH))  w_eff = CNT_W'(MAX_WIDTH);
      else                                    w_eff = width_ff;
      if (palcnt_ff == '0)                        n_eff = PAL_CNT_W'(1);
      else if (palcnt_ff > PAL_CNT_W'(PAL_DEPTH)) n_eff = PAL_CNT_W'(PAL_DEPTH);
      else                                        n_eff = palcnt_ff;
      col_next = {1'b0, col_ff} + CNT_W'(1);
      last     = col_next >= w_eff;
      cnt_this = sel_ff ? cnt_b_ff : cnt_a_ff;
      cnt_next = sel_ff ? cnt_a_ff : cnt_b_ff;
   end

   // Channel adjustment: diffused error, threshold offset, clamp
   always_comb begin
      this_rd = sel_ff ? b_rdata : a_rdata;
      next_rd = sel_ff ? a_rdata : b_rdata;
      for (int k = 0; k < 3; k++) begin
         err_sum[k] = signed'(this_rd[ERR_W*k +: ERR_W]) + signed'(carry_ff[ERR_W*k +: ERR_W]);
         err_rnd[k] = err_sum[k] + (err_sum[k][ERR_W-1] ? 13'sd15 : 13'sd0);
         unique case (mode_ff)
            MODE_DIFFUSE: adj[k] = 10'(err_rnd[k] >>> 4);
            MODE_BAYER4:
               adj[k] = (signed'({6'd0, BAYER4[{row_ff[1:0], col_ff[1:0]}]}) - 10'sd8) <<< 2;
            MODE_ORDER8:
               adj[k] = (signed'({4'd0, ORDER8[{row_ff, col_ff[2:0]}]}) - 10'sd32) <<< 1;
            default: adj[k] = '0;
         endcase
         adj_sum[k] = signed'({3'd0, pix_ff[23-8*k -: 8]}) + 11'(adj[k]);
         if (adj_sum[k] < 0)              chan_in[23-8*k -: 8] = 8'd0;
         else if (adj_sum[k] > 11'sd255)  chan_in[23-8*k -: 8] = 8'hFF;
         else                             chan_in[23-8*k -: 8] = adj_sum[k][7:0];
      end
   end

   // Quantization error and its weighted shares
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         e13[k] = signed'({5'd0, chan_ff[23-8*k -: 8]}) - signed'({5'd0, srch_stat.rgb[23-8*k -: 8]});
         unique case (step_ff)
            2'd1:    wgt[k] = (e13[k] <<< 1) + e13[k];
            2'd2:    wgt[k] = (e13[k] <<< 2) + e13[k];
            default: wgt[k] = e13[k];
         endcase
         seven_e[ERR_W*k +: ERR_W]    = (e13[k] <<< 3) - e13[k];
         next_wdata[ERR_W*k +: ERR_W] = next_rd[ERR_W*k +: ERR_W] + wgt[k];
      end
   end

   // Line store addressing: this row's store is read and zeroed, the next row's is
   // read, updated and written back one entry per step
   always_comb begin
      diff_rsum  = {1'b0, col_ff} + CNT_W'(step_ff) - CNT_W'(1);
      diff_wsum  = {1'b0, col_ff} + CNT_W'(step_ff) - CNT_W'(2);
      next_raddr = diff_rsum[ADDR_W-1:0];
      next_waddr = diff_wsum[ADDR_W-1:0];
      unique case (step_ff)
         2'd1:    diff_ok = col_ff != '0;
         2'd2:    diff_ok = 1'b1;
         2'd3:    diff_ok = !last;
         default: diff_ok = 1'b0;
      endcase
      this_addr = col_ff;
      this_we   = state_ff == ST_READ;
      next_we   = (state_ff == ST_DIFF) && diff_ok;

      a_raddr = sel_ff ? next_raddr : this_addr;
      b_raddr = sel_ff ? this_addr : next_raddr;
      a_we    = sel_ff ? next_we : this_we;
      b_we    = sel_ff ? this_we : next_we;
      a_waddr = sel_ff ? next_waddr : this_addr;
      b_waddr = sel_ff ? this_addr : next_waddr;
      a_wdata = sel_ff ? next_wdata : '0;
      b_wdata = sel_ff ? '0 : next_wdata;

      if ((state_ff == ST_SWEEP) && (clr_addr_ff < clr_end_ff)) begin
         a_we    = clr_a_ff;
         b_we    = clr_b_ff;
         a_waddr = clr_addr_ff[ADDR_W-1:0];
         b_waddr = clr_addr_ff[ADDR_W-1:0];
         a_wdata = '0;
         b_wdata = '0;
      end
   end

   pd_ram #(.DEPTH(MAX_WIDTH), .WIDTH(ERR_WORD_W)) u_bank_a (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (a_waddr),
      .wr_data (a_wdata),
      .rd_addr (a_raddr),
      .rd_data (a_rdata)
   );

   pd_ram #(.DEPTH(MAX_WIDTH), .WIDTH(ERR_WORD_W)) u_bank_b (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (b_waddr),
      .wr_data (b_wdata),
      .rd_addr (b_raddr),
      .rd_data (b_rdata)
   );

   assign req_take = req_tvalid && req_tready;

   pd_search u_search (
      .clock   (clock),
      .reset   (reset),
      .pal_we  (req_take && (req_tuser[0] == KIND_PALETTE)),
      .pal_idx (req_tdata[3:0]),
      .pal_rgb (req_tdata[27:4]),
      .start   (srch_start),
      .target  (chan_ff),
      .count   (n_eff),
      .stat    (srch_stat)
   );

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      pix_in       = pix_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      sel_in       = sel_ff;
      cnt_a_in     = cnt_a_ff;
      cnt_b_in     = cnt_b_ff;
      carry_in     = carry_ff;
      clr_addr_in  = clr_addr_ff;
      clr_end_in   = clr_end_ff;
      clr_a_in     = clr_a_ff;
      clr_b_in     = clr_b_ff;
      step_in      = step_ff;
      srch_start   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_tuser[0] == KIND_PIXEL)) begin
               pix_in = req_tdata[51:28];
               if (req_tuser[1]) begin
                  col_in      = '0;
                  row_in      = '0;
                  carry_in    = '0;
                  cnt_a_in    = '0;
                  cnt_b_in    = '0;
                  clr_addr_in = '0;
                  clr_end_in  = (cnt_a_ff > cnt_b_ff) ? cnt_a_ff : cnt_b_ff;
                  clr_a_in    = 1'b1;
                  clr_b_in    = 1'b1;
                  ret_in      = ST_READ;
                  state_in    = ST_SWEEP;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_SWEEP: begin
            if (clr_addr_ff < clr_end_ff) begin
               clr_addr_in = clr_addr_ff + CNT_W'(1);
            end else begin
               state_in = ret_ff;
            end
         end
         ST_READ: begin
            state_in = ST_ADJ;
         end
         ST_ADJ: begin
            if (mode_ff == MODE_PASS) begin
               state_in = ST_END;
            end else begin
               srch_start = 1'b1;
               state_in   = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (srch_stat.done) begin
               step_in  = '0;
               state_in = (mode_ff == MODE_DIFFUSE) ? ST_DIFF : ST_END;
            end
         end
         ST_DIFF: begin
            step_in = step_ff + 2'd1;
            if (next_we && ((diff_wsum + CNT_W'(1)) > cnt_next)) begin
               if (sel_ff) cnt_a_in = diff_wsum + CNT_W'(1);
               else        cnt_b_in = diff_wsum + CNT_W'(1);
            end
            if (step_ff == 2'd3) begin
               state_in = ST_END;
            end
         end
         ST_END: begin
            // Zero stale entries beyond this row's end before the stores swap
            if (last && (cnt_this > col_next)) begin
               clr_addr_in = col_next;
               clr_end_in  = cnt_this;
               clr_a_in    = !sel_ff;
               clr_b_in    = sel_ff;
               ret_in      = ST_OUT;
               state_in    = ST_SWEEP;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = last;
               if (mode_ff == MODE_PASS) begin
                  rsp_data_in = {4'd0, 4'd0, pix_ff};
               end else begin
                  rsp_data_in = {4'd0, srch_stat.index, srch_stat.rgb};
               end
               carry_in = ((mode_ff == MODE_DIFFUSE) && !last) ? seven_e : '0;
               if (last) begin
                  sel_in = !sel_ff;
                  if (sel_ff) cnt_b_in = '0;
                  else        cnt_a_in = '0;
                  col_in = '0;
                  row_in = row_ff + 3'd1;
               end else begin
                  col_in = col_next[ADDR_W-1:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         ret_ff       <= ST_IDLE;
         clr_addr_ff  <= '0;
         clr_end_ff   <= CNT_W'(MAX_WIDTH);
         clr_a_ff     <= 1'b1;
         clr_b_ff     <= 1'b1;
         col_ff       <= '0;
         row_ff       <= '0;
         sel_ff       <= 1'b0;
         cnt_a_ff     <= '0;
         cnt_b_ff     <= '0;
         carry_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         clr_addr_ff  <= clr_addr_in;
         clr_end_ff   <= clr_end_in;
         clr_a_ff     <= clr_a_in;
         clr_b_ff     <= clr_b_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         sel_ff       <= sel_in;
         cnt_a_ff     <= cnt_a_in;
         cnt_b_ff     <= cnt_b_in;
         carry_ff     <= carry_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pix_ff      <= pix_in;
      chan_ff     <= (state_ff == ST_ADJ) ? chan_in : chan_ff;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_done_in_search: assert property (@(posedge clock) disable iff (reset)
      srch_stat.done |-> state_ff == ST_SEARCH)
      else $error("search finished outside the search step");

   a_result_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result loaded outside the output step");

   a_palette_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_tuser[0] == KIND_PALETTE)) |=> state_ff == ST_IDLE)
      else $error("palette request left the idle state");

endmodule
`default_nettype wire
